// ===== sv/assert_macros.svh =====
// Assertion macros shared by the twiddle generator RTL.
// Included by the top level; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) cond) \
		else $error("assertion failed");
// A signal keeps its value after each cycle in which hold is true.
`define ASSERT_HOLD(label, clk, rst_n, hold, sig) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (hold) |=> $stable(sig)) \
		else $error("assertion failed");
`endif

// ===== sv/ntg_pkg.sv =====
// Package for the NTT twiddle generator: config register indexes.
// No dependencies.
`default_nettype none
package ntg_pkg;
	localparam int unsigned CFG_IDX_BITS = 2;
	localparam logic [CFG_IDX_BITS-1:0] REG_LOG_SIZE = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_ROOT     = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_MODULUS  = 2'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_INV_MODE = 2'd3;
endpackage
`default_nettype wire

// ===== sv/ntg_modmul.sv =====
// Bit-serial modular multiplier (shift-add with conditional subtract).
// Standalone; used by ntt_twiddle_generator.
`default_nettype none
module ntg_modmul #(
	parameter int unsigned W = 32
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	input  wire logic [W-1:0] a,
	input  wire logic [W-1:0] b,
	input  wire logic [W-1:0] q,
	output logic              done,
	output logic [W-1:0]      p
);
	localparam int unsigned CW = $clog2(W + 1);
	logic [W-1:0] b_q;
	logic [CW-1:0] cnt_q;
	logic busy_q;
	logic [W:0] dbl, dsub, acc_add, asub;
	logic [W-1:0] dred;

	always_comb begin
		// p < q: 2p - q fits in W+1 bits.
		dbl = {p, 1'b0};
		dsub = dbl - {1'b0, q};
		dred = (dbl >= {1'b0, q}) ? dsub[W-1:0] : dbl[W-1:0];
		acc_add = {1'b0, dred} + {1'b0, a};
		asub = acc_add - {1'b0, q};
		if (!b_q[W-1]) acc_add = {1'b0, dred};
		else if (acc_add >= {1'b0, q}) acc_add = asub;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				b_q <= b;
				p <= '0;
				cnt_q <= CW'(W);
			end else if (busy_q) begin
				p <= acc_add[W-1:0];
				b_q <= {b_q[W-2:0], 1'b0};
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end
endmodule
`default_nettype wire

// ===== sv/ntt_twiddle_generator.sv =====
// NTT twiddle generator: one request in, one result out, one at a time.
// Steps: the root is reduced mod q by bit-serial division, then raised to the exponent
// by square-and-multiply (up to 2*MAX_LOG_SIZE+1 multiplies); inverse mode adds Euclid
// with bit-serial division. A new request waits until the last result has been accepted.
// Reset: asynchronous, active low; config returns to log_size 3, root 2, modulus 17.
`default_nettype none
`include "assert_macros.svh"
module ntt_twiddle_generator #(
	parameter int unsigned MAX_LOG_SIZE = 10,
	parameter int unsigned MOD_BITS = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [9:0]  index,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [31:0]      twiddle,
	output logic             no_inverse
);
	localparam int unsigned W = MOD_BITS;
	localparam int unsigned LB = $clog2(MAX_LOG_SIZE + 1);
	localparam int unsigned DW = $clog2(W + 1);

	typedef enum logic [3:0] {
		ST_IDLE, ST_ROOT, ST_PMUL, ST_PSQR, ST_ZMUL, ST_EUC,
		ST_DIV, ST_TUPD, ST_FIN, ST_OUT
	} state_t;
	state_t state_q;

	// Configuration registers.
	logic [3:0]   log_size_q;
	logic [W-1:0] root_q, mod_q;
	logic         inv_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			log_size_q <= 4'd3;
			root_q <= W'(2);
			mod_q <= W'(17);
			inv_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ntg_pkg::REG_LOG_SIZE: log_size_q <= cfg_data[3:0];
				ntg_pkg::REG_ROOT:     root_q <= cfg_data[W-1:0];
				ntg_pkg::REG_MODULUS:  mod_q <= cfg_data[W-1:0];
				ntg_pkg::REG_INV_MODE: inv_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Exponent: bit-reversed index over the effective size.
	logic [LB-1:0] bits_eff;
	logic [MAX_LOG_SIZE-1:0] kin, erev;
	always_comb begin
		bits_eff = (log_size_q > 4'(MAX_LOG_SIZE)) ? LB'(MAX_LOG_SIZE) : LB'(log_size_q);
		kin = MAX_LOG_SIZE'(index);
		erev = '0;
		for (int i = 0; i < MAX_LOG_SIZE; i++)
			if (i < int'(bits_eff)) erev[int'(bits_eff) - 1 - i] = kin[i];
	end

	// Shared serial multiplier.
	logic         mm_start, mm_done;
	logic [W-1:0] mm_a, mm_b, mm_p;
	ntg_modmul #(.W(W)) u_mul (
		.clk(clk), .arst_n(arst_n), .start(mm_start),
		.a(mm_a), .b(mm_b), .q(mod_q), .done(mm_done), .p(mm_p)
	);

	logic [MAX_LOG_SIZE-1:0] e_q;
	logic [W-1:0] base_q, acc_q, z_q;
	logic         started_q;
	// Euclid state: remainders and signed Bezout coefficients.
	logic [W-1:0] r0_q, r1_q, quo_q, rem_q;
	logic signed [W+1:0] t0_q, t1_q;
	logic [DW-1:0] dcnt_q;
	logic [W:0] rtrial;
	logic signed [2*W+3:0] prod;
	logic signed [W+1:0] tnew;

	always_comb begin
		rtrial = {rem_q, quo_q[W-1]} - {1'b0, r1_q};
		// |t| <= q, quotient < 2^W; product fits 2W+4 bits.
		prod = t1_q * $signed({2'b00, quo_q});
		tnew = t0_q - prod[W+1:0];
	end

	// Multiplier operands: accumulate, square the base, or fold in the root once more.
	always_comb begin
		mm_a = acc_q;
		mm_b = base_q;
		if (state_q == ST_PSQR) mm_a = base_q;
		else if (state_q == ST_ZMUL) mm_b = z_q;
	end

	assign in_stall = (state_q != ST_IDLE);
	assign mm_start = !started_q && (state_q == ST_PMUL || state_q == ST_PSQR ||
		state_q == ST_ZMUL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid <= 1'b0;
			started_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: if (in_valid) begin
					e_q <= erev;
					no_inverse <= 1'b0;
					twiddle <= '0;
					if (mod_q < W'(2)) begin
						out_valid <= 1'b1;
						state_q <= ST_OUT;
					end else begin
						// root mod q via serial division
						quo_q <= root_q;
						rem_q <= '0;
						r1_q <= mod_q;
						dcnt_q <= DW'(W);
						state_q <= ST_ROOT;
					end
				end
				ST_ROOT: begin
					quo_q <= {quo_q[W-2:0], !rtrial[W]};
					rem_q <= rtrial[W] ? {rem_q[W-2:0], quo_q[W-1]} : rtrial[W-1:0];
					dcnt_q <= dcnt_q - 1'b1;
					if (dcnt_q == DW'(1)) begin
						z_q <= rtrial[W] ? {rem_q[W-2:0], quo_q[W-1]} : rtrial[W-1:0];
						base_q <= rtrial[W] ? {rem_q[W-2:0], quo_q[W-1]} : rtrial[W-1:0];
						acc_q <= W'(1);
						state_q <= ST_PMUL;
					end
				end
				ST_PMUL: begin
					if (e_q == '0) begin
						if (inv_q) state_q <= ST_ZMUL;
						else begin
							twiddle <= 32'(acc_q);
							out_valid <= 1'b1;
							state_q <= ST_OUT;
						end
					end else if (!e_q[0]) state_q <= ST_PSQR;
					else if (!started_q) started_q <= 1'b1;
					else if (mm_done) begin
						acc_q <= mm_p;
						started_q <= 1'b0;
						state_q <= ST_PSQR;
					end
				end
				ST_PSQR: begin
					if (!started_q) started_q <= 1'b1;
					else if (mm_done) begin
						base_q <= mm_p;
						e_q <= e_q >> 1;
						started_q <= 1'b0;
						state_q <= ST_PMUL;
					end
				end
				ST_ZMUL: begin
					if (!started_q) started_q <= 1'b1;
					else if (mm_done) begin
						started_q <= 1'b0;
						r0_q <= mod_q;
						r1_q <= mm_p;
						t0_q <= '0;
						t1_q <= (W+2)'(1);
						state_q <= ST_EUC;
					end
				end
				ST_EUC: begin
					if (r1_q == '0) state_q <= ST_FIN;
					else begin
						quo_q <= r0_q;
						rem_q <= '0;
						dcnt_q <= DW'(W);
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					quo_q <= {quo_q[W-2:0], !rtrial[W]};
					rem_q <= rtrial[W] ? {rem_q[W-2:0], quo_q[W-1]} : rtrial[W-1:0];
					dcnt_q <= dcnt_q - 1'b1;
					if (dcnt_q == DW'(1)) state_q <= ST_TUPD;
				end
				ST_TUPD: begin
					r0_q <= r1_q;
					r1_q <= rem_q;
					t0_q <= t1_q;
					t1_q <= tnew;
					state_q <= ST_EUC;
				end
				ST_FIN: begin
					if (r0_q != W'(1)) no_inverse <= 1'b1;
					else if (t0_q < 0) twiddle <= 32'(t0_q + $signed({2'b00, mod_q}));
					else twiddle <= 32'(t0_q);
					out_valid <= 1'b1;
					state_q <= ST_OUT;
				end
				ST_OUT: if (!out_stall) begin
					out_valid <= 1'b0;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`ASSERT_IMPL(a_out_only_in_out, clk, arst_n, out_valid |-> state_q == ST_OUT)
	`ASSERT_IMPL(a_stall_busy, clk, arst_n, (state_q != ST_IDLE) |-> in_stall)
	`ASSERT_IMPL(a_tw_range, clk, arst_n, (out_valid && mod_q >= W'(2)) |-> twiddle < 32'(mod_q))
	`ASSERT_IMPL(a_flag_zero, clk, arst_n, (out_valid && no_inverse) |-> twiddle == '0)
	`ASSERT_HOLD(a_out_hold, clk, arst_n, out_valid && out_stall, twiddle)
endmodule
`default_nettype wire
